@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the core RTL.
// Every check samples on the rising edge of clk and is ignored while rst is high.
// Compiling with NO_ASSERTIONS defined leaves every macro empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property that holds at one sampled edge.
`define CHECK_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks a consequence that holds in the cycle after its antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define CHECK_AT(label, prop, msg)
`define CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/slpg_pkg.sv @@
package slpg_pkg;

  // Width of the step register.
  localparam int STEP_BITS = 4;

  // Register index on the configuration port.
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_X_START   = 3'd0;
  localparam cfg_index_t REG_Y_START   = 3'd1;
  localparam cfg_index_t REG_X_END     = 3'd2;
  localparam cfg_index_t REG_Y_END     = 3'd3;
  localparam cfg_index_t REG_STEP_SIZE = 3'd4;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_RESET = 4'd1;

endpackage

@@ rtl/core/stepped_line_point_generator.sv @@
// Stepped line point generator.
// Command channel (cmd_valid / cmd_stall, payload restart): restart 1 starts a
// new line from the endpoint registers and returns its first point; restart 0
// returns the next point of the running line. Every command gives one result
// beat on the result channel (res_valid / res_stall): point_x, point_y,
// point_valid (0 once the line is finished or empty, coordinates then 0) and
// last_point. Registers are written on cfg_we with cfg_index / cfg_data.
// Each command is worked through the states PREP1, PREP2, MUL, DIVPREP, DIV and
// FIN; a new command is taken only once the last one has loaded its result.
// Points come from one bit-serial multiplier (COORD_BITS steps) and one
// restoring divider (2*COORD_BITS+2 steps) shared by every point.
// A command that yields no point, or a line with no major-axis run, goes straight
// to FIN; when the live major delta is zero, PREP2 skips multiplier and divider.
// The result sits in an output register: while res_stall is high it holds, and
// one more command may be taken and worked on meanwhile.
// Reset (rst, synchronous) clears the registers to their defaults (step 1),
// stops any running line and empties the result register.
`include "assert_macros.svh"

module stepped_line_point_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  slpg_pkg::cfg_index_t                cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  // command channel
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic                                restart,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [COORD_BITS-1:0]        point_x,
  output logic signed [COORD_BITS-1:0]        point_y,
  output logic                                point_valid,
  output logic                                last_point
);

  import slpg_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;          // coordinate difference
  localparam int AW = 2 * CB + 2;      // product sum and dividend
  localparam int RW = CB + 2;          // divider partial remainder
  localparam int CW = $clog2(AW + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PREP1   = 3'd1;
  localparam logic [2:0] S_PREP2   = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_DIVPREP = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  // configuration
  logic signed [CB-1:0] x_start, y_start, x_end, y_end;
  step_t                step_size;

  // line state
  logic signed [CB-1:0] major_position, major_limit;
  logic                 x_is_major, line_active;

  // control
  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic          emit;
  logic          da_zero;

  // datapath
  logic signed [DW-1:0] da_raw, db_raw, dm_raw, db_eff;
  logic [CB-1:0]        da_mag, mul_a, mul_b;
  logic signed [AW-1:0] acc;
  logic                 nneg;
  logic [AW-1:0]        dividend;
  logic [CB:0]          dvs;
  logic [RW-1:0]        rem;
  logic [CB-1:0]        quo;

  logic cmd_accept, out_free;

  // ---------------------------------------------------------------
  // Restart set-up: axis choice, start and limit of the major run
  // ---------------------------------------------------------------
  logic signed [DW-1:0] dx, dy, ndx, ndy;
  logic [CB-1:0]        adx, ady;
  logic                 set_x_major, set_active;
  logic signed [CB-1:0] set_pos, set_lim;

  assign dx  = $signed({x_end[CB-1], x_end}) - $signed({x_start[CB-1], x_start});
  assign dy  = $signed({y_end[CB-1], y_end}) - $signed({y_start[CB-1], y_start});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[DW-1] ? ndx[CB-1:0] : dx[CB-1:0];
  assign ady = dy[DW-1] ? ndy[CB-1:0] : dy[CB-1:0];
  assign set_x_major = (ady <= adx);

  always_comb begin
    if (set_x_major) begin
      set_pos    = dx[DW-1] ? x_end : x_start;
      set_lim    = dx[DW-1] ? x_start : x_end;
      set_active = (dx != '0);
    end else begin
      set_pos    = dy[DW-1] ? y_end : y_start;
      set_lim    = dy[DW-1] ? y_start : y_end;
      set_active = (dy != '0);
    end
  end

  // ---------------------------------------------------------------
  // Line equation operands: a is the major axis, b the minor one
  // ---------------------------------------------------------------
  logic signed [CB-1:0] a0, a1, b0, b1;

  assign a0 = x_is_major ? x_start : y_start;
  assign a1 = x_is_major ? x_end   : y_end;
  assign b0 = x_is_major ? y_start : x_start;
  assign b1 = x_is_major ? y_end   : x_end;

  // sign folding for the serial multiplier
  logic signed [DW-1:0] nda, ndb, ndm;
  logic                 da_neg, dm_neg;

  assign nda    = -da_raw;
  assign ndb    = -db_raw;
  assign ndm    = -dm_raw;
  assign da_neg = da_raw[DW-1];
  assign dm_neg = dm_raw[DW-1];

  // one shift-add step: acc = 2*acc + bit_a*b0 + bit_b*db
  logic signed [AW-1:0] pa, pb, acc_sh;

  assign pa     = mul_a[CB-1] ? $signed({{(AW-CB){b0[CB-1]}}, b0}) : '0;
  assign pb     = mul_b[CB-1] ? $signed({{(AW-DW){db_eff[DW-1]}}, db_eff}) : '0;
  assign acc_sh = $signed({acc[AW-2:0], 1'b0});

  // dividend = 2*|n| + da, modulo 2^AW (true value fits)
  logic [AW-1:0] acc_x2, da_ext;

  assign acc_x2 = {acc[AW-2:0], 1'b0};
  assign da_ext = AW'(da_mag);

  // one restoring division step
  logic [RW-1:0] trial, dvs_ext;
  logic          ge;

  assign trial   = {rem[RW-2:0], dividend[AW-1]};
  assign dvs_ext = RW'(dvs);
  assign ge      = (trial >= dvs_ext);

  // ---------------------------------------------------------------
  // Result assembly and advance of the major coordinate
  // ---------------------------------------------------------------
  logic [CB-1:0]        nquo, minor;
  step_t                step_eff;
  logic signed [DW-1:0] next_pos, lim_ext;
  logic                 run_done;

  assign nquo     = -quo;
  assign minor    = da_zero ? b0 : (nneg ? nquo : quo);
  assign step_eff = (step_size == '0) ? STEP_RESET : step_size;
  assign next_pos = $signed({major_position[CB-1], major_position}) +
                    $signed(DW'(step_eff));
  assign lim_ext  = $signed({major_limit[CB-1], major_limit});
  assign run_done = (next_pos >= lim_ext);

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign out_free   = !res_valid || !res_stall;

  // ---------------------------------------------------------------
  // Control, configuration and line state
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_start        <= '0;
      y_start        <= '0;
      x_end          <= '0;
      y_end          <= '0;
      step_size      <= STEP_RESET;
      major_position <= '0;
      major_limit    <= '0;
      x_is_major     <= 1'b1;
      line_active    <= 1'b0;
      state          <= S_IDLE;
      cnt            <= '0;
      emit           <= 1'b0;
      da_zero        <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_X_START:   x_start   <= cfg_data;
          REG_Y_START:   y_start   <= cfg_data;
          REG_X_END:     x_end     <= cfg_data;
          REG_Y_END:     y_end     <= cfg_data;
          REG_STEP_SIZE: step_size <= cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end

      // result register: load a finished beat, else drop a taken one
      if (state == S_FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            if (restart) begin
              x_is_major     <= set_x_major;
              major_position <= set_pos;
              major_limit    <= set_lim;
              line_active    <= set_active;
            end
            emit  <= restart ? set_active : line_active;
            state <= (restart ? set_active : line_active) ? S_PREP1 : S_FIN;
          end
        end
        S_PREP1: begin
          state <= S_PREP2;
        end
        S_PREP2: begin
          da_zero <= (da_raw == '0);
          cnt     <= '0;
          state   <= (da_raw == '0) ? S_FIN : S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(CB - 1)) begin
            state <= S_DIVPREP;
          end
        end
        S_DIVPREP: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(AW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (emit) begin
              if (run_done) begin
                line_active <= 1'b0;
              end else begin
                major_position <= next_pos[CB-1:0];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Arithmetic datapath
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_PREP1: begin
        da_raw <= $signed({a1[CB-1], a1}) - $signed({a0[CB-1], a0});
        db_raw <= $signed({b1[CB-1], b1}) - $signed({b0[CB-1], b0});
        dm_raw <= $signed({major_position[CB-1], major_position}) -
                  $signed({a0[CB-1], a0});
      end
      S_PREP2: begin
        da_mag <= da_neg ? nda[CB-1:0] : da_raw[CB-1:0];
        mul_a  <= da_neg ? nda[CB-1:0] : da_raw[CB-1:0];
        mul_b  <= dm_neg ? ndm[CB-1:0] : dm_raw[CB-1:0];
        db_eff <= (da_neg ^ dm_neg) ? ndb : db_raw;
        acc    <= '0;
      end
      S_MUL: begin
        acc   <= acc_sh + pa + pb;
        mul_a <= {mul_a[CB-2:0], 1'b0};
        mul_b <= {mul_b[CB-2:0], 1'b0};
      end
      S_DIVPREP: begin
        nneg     <= acc[AW-1];
        dividend <= acc[AW-1] ? (da_ext - acc_x2) : (da_ext + acc_x2);
        dvs      <= {da_mag, 1'b0};
        rem      <= '0;
        quo      <= '0;
      end
      S_DIV: begin
        rem      <= ge ? (trial - dvs_ext) : trial;
        dividend <= {dividend[AW-2:0], 1'b0};
        quo      <= {quo[CB-2:0], ge};
      end
      default: ;
    endcase
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      if (emit) begin
        point_x     <= x_is_major ? major_position : $signed(minor);
        point_y     <= x_is_major ? $signed(minor) : major_position;
        point_valid <= 1'b1;
        last_point  <= run_done;
      end else begin
        point_x     <= '0;
        point_y     <= '0;
        point_valid <= 1'b0;
        last_point  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `CHECK_AT(a_pos_below_limit, line_active |-> major_position < major_limit, "position reached limit on a running line")
  `CHECK_AT(a_empty_beat_zero, res_valid && !point_valid |-> point_x == '0 && point_y == '0 && !last_point, "empty beat carries data")
  `CHECK_AT(a_rem_below_dvs, state == S_DIV |-> rem < {1'b0, dvs}, "divider remainder out of range")
  `CHECK_NEXT(a_fin_loads_result, state == S_FIN && out_free, res_valid && state == S_IDLE, "finished point not loaded")

endmodule

@@ bench/line_point_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration port and both channels of the line point generator,
// predicts every result beat and compares it with what the block returns.
module line_point_checker #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  slpg_pkg::cfg_index_t         cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic                         restart,
  input  logic                         res_valid,
  input  logic                         res_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         point_valid,
  input  logic                         last_point,
  output int                           mismatch_count,
  output int                           points_outstanding
);
  import slpg_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  valid;
    logic                  last;
  } line_point_t;

  // shadow of the endpoint and step registers
  logic signed [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
  step_t                        step_q;

  // walk state latched on restart
  longint walk_pos, walk_limit;
  bit     walk_on_x, walk_active;

  line_point_t expected_points[$];
  int          beat_no;

  task automatic report_mismatch(input string msg);
    $display("line point check: %s", msg);
    mismatch_count++;
  endtask

  // n/d rounded half away from zero, d > 0
  function automatic longint round_half_away(input longint n, input longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  // minor coordinate at major coordinate m, line a0->a1 (major), b0->b1 (minor)
  function automatic longint minor_on_line(input longint m, input longint a0,
                                           input longint a1, input longint b0,
                                           input longint b1);
    longint da, db;
    da = a1 - a0;
    db = b1 - b0;
    if (da == 0) return b0;
    if (da < 0) begin
      da = -da;
      db = -db;
    end
    return round_half_away(b0 * da + (m - a0) * db, da);
  endfunction

  // next point of the line; advances the walk state
  function automatic line_point_t trace_point(input bit rs);
    longint      xs, ys, xe, ye, stride, lo, hi, px, py;
    line_point_t p;
    xs = x0_q;
    ys = y0_q;
    xe = x1_q;
    ye = y1_q;
    stride = (step_q == '0) ? 1 : longint'(step_q);
    p = '0;
    if (rs) begin
      walk_on_x = ((ye < ys) ? ys - ye : ye - ys) <= ((xe < xs) ? xs - xe : xe - xs);
      lo = walk_on_x ? xs : ys;
      hi = walk_on_x ? xe : ye;
      walk_pos = (lo < hi) ? lo : hi;
      walk_limit = (lo < hi) ? hi : lo;
      walk_active = walk_pos < walk_limit;
    end
    if (!walk_active) return p;
    if (walk_on_x) begin
      px = walk_pos;
      py = minor_on_line(px, xs, xe, ys, ye);
    end else begin
      py = walk_pos;
      px = minor_on_line(py, ys, ye, xs, xe);
    end
    if (walk_pos + stride >= walk_limit) begin
      walk_active = 1'b0;
      p.last = 1'b1;
    end else begin
      walk_pos = walk_pos + stride;
    end
    p.x = px[COORD_BITS-1:0];
    p.y = py[COORD_BITS-1:0];
    p.valid = 1'b1;
    return p;
  endfunction

  initial begin
    mismatch_count = 0;
    points_outstanding = 0;
    beat_no = 0;
  end

  always @(posedge clk) begin
    line_point_t want;
    if (rst) begin
      x0_q <= '0;
      y0_q <= '0;
      x1_q <= '0;
      y1_q <= '0;
      step_q <= STEP_RESET;
      walk_pos = 0;
      walk_limit = 0;
      walk_on_x = 1'b1;
      walk_active = 1'b0;
      expected_points.delete();
    end else begin
      // register writes only happen while the block is idle
      if (cfg_we) begin
        case (cfg_index)
          REG_X_START:   x0_q <= cfg_data;
          REG_Y_START:   y0_q <= cfg_data;
          REG_X_END:     x1_q <= cfg_data;
          REG_Y_END:     y1_q <= cfg_data;
          REG_STEP_SIZE: step_q <= cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (res_valid && !res_stall) begin
        beat_no++;
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with no command outstanding",
                                    beat_no));
        end else begin
          want = expected_points.pop_front();
          if (point_x !== want.x)
            report_mismatch($sformatf("beat %0d point_x: expected %0d, got %0d",
                                      beat_no, $signed(want.x), point_x));
          if (point_y !== want.y)
            report_mismatch($sformatf("beat %0d point_y: expected %0d, got %0d",
                                      beat_no, $signed(want.y), point_y));
          if (point_valid !== want.valid)
            report_mismatch($sformatf("beat %0d point_valid: expected %0d, got %0d",
                                      beat_no, want.valid, point_valid));
          if (last_point !== want.last)
            report_mismatch($sformatf("beat %0d last_point: expected %0d, got %0d",
                                      beat_no, want.last, last_point));
        end
      end
      // command beat: predict with the registers as they stand now
      if (cmd_valid && !cmd_stall)
        expected_points.push_back(trace_point(restart));
    end
    points_outstanding = expected_points.size();
  end

endmodule

@@ bench/tb_stepped_line_point_generator.sv @@
`timescale 1ns / 100ps

module tb_stepped_line_point_generator;
  import slpg_pkg::*;

  localparam int COORD_BITS      = 12;
  localparam int RANDOM_COMMANDS = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int MAX_WALK        = 40;

  typedef logic [COORD_BITS-1:0] coord_bits_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  cfg_index_t                   cfg_index;
  coord_bits_t                  cfg_data;
  logic                         cmd_valid;
  logic                         cmd_stall;
  logic                         restart;
  logic                         res_valid;
  logic                         res_stall;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         point_valid;
  logic                         last_point;
  int                           mismatch_count;
  int                           points_outstanding;

  bit tx_idle, rx_idle, hold_off_req;
  int commands_offered;
  int quiet_cycles;
  // register values as last written, and the area the short lines sit in
  int cur_x0, cur_y0, cur_x1, cur_y1, cur_step;
  int area_x, area_y;

  cfg_index_t all_regs[5] = '{REG_X_START, REG_Y_START, REG_X_END, REG_Y_END,
                              REG_STEP_SIZE};

  stepped_line_point_generator #(.COORD_BITS(COORD_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .restart(restart),
    .res_valid(res_valid), .res_stall(res_stall),
    .point_x(point_x), .point_y(point_y),
    .point_valid(point_valid), .last_point(last_point)
  );

  line_point_checker #(.COORD_BITS(COORD_BITS)) u_point_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .restart(restart),
    .res_valid(res_valid), .res_stall(res_stall),
    .point_x(point_x), .point_y(point_y),
    .point_valid(point_valid), .last_point(last_point),
    .mismatch_count(mismatch_count), .points_outstanding(points_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  // cycles of no valid before the next command beat
  function automatic int sender_gap();
    if (!tx_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // coordinate near an area center, at a range extreme, or anywhere
  function automatic int pick_coord(input int center);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: v = -2048;
        1: v = 2047;
        2: v = -1;
        default: v = 0;
      endcase
    end else if (r < 25) begin
      v = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      v = center + int'($urandom_range(0, 60)) - 30;
      if (v < -2048) v = -2048;
      if (v > 2047) v = 2047;
    end
    return v;
  endfunction

  // step values carry random upper bits, which the register drops
  function automatic int reg_value(input cfg_index_t idx);
    case (idx)
      REG_X_START, REG_X_END: return pick_coord(area_x);
      REG_Y_START, REG_Y_END: return pick_coord(area_y);
      default: return int'($urandom_range(0, 255) << 4) | int'($urandom_range(0, 15));
    endcase
  endfunction

  // offer one command beat and wait for it to be taken
  task automatic offer_command(input bit rs);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid = 1'b1;
    restart = rs;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    commands_offered++;
    @(negedge clk);
  endtask

  // register write once every outstanding point has come back
  task automatic write_reg(input cfg_index_t idx, input int value);
    cmd_valid = 1'b0;
    while (points_outstanding != 0) @(negedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = coord_bits_t'(value);
    case (idx)
      REG_X_START:   cur_x0 = $signed(cfg_data);
      REG_Y_START:   cur_y0 = $signed(cfg_data);
      REG_X_END:     cur_x1 = $signed(cfg_data);
      REG_Y_END:     cur_y1 = $signed(cfg_data);
      REG_STEP_SIZE: cur_step = cfg_data[STEP_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_line(input int x0, input int y0, input int x1, input int y1,
                          input int stride);
    write_reg(REG_X_START, x0);
    write_reg(REG_Y_START, y0);
    write_reg(REG_X_END, x1);
    write_reg(REG_Y_END, y1);
    write_reg(REG_STEP_SIZE, stride);
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        res_stall = 1'b0;
      end else if (rx_idle && $urandom_range(0, 2) == 0) begin
        res_stall = 1'b1;
        repeat (idle_len()) @(negedge clk);
        res_stall = 1'b0;
      end
    end
  end

  // watchdog: too long without any beat or register write
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || cfg_we || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int  random_start, span, stride, full, nnext, lines;
    bit  first_phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_X_START;
    cfg_data = '0;
    cmd_valid = 1'b0;
    restart = 1'b0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_off_req = 1'b0;
    commands_offered = 0;
    cur_x0 = 0;
    cur_y0 = 0;
    cur_x1 = 0;
    cur_y1 = 0;
    cur_step = 1;
    area_x = 0;
    area_y = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: no line running, then coincident endpoints out of reset
    offer_command(1'b0);
    offer_command(1'b1);
    // shallow slope, walked past its end
    set_line(0, 0, 3, 1, 1);
    offer_command(1'b1);
    repeat (3) offer_command(1'b0);
    // negative half value rounds away from zero
    set_line(0, 0, 2, -1, 1);
    offer_command(1'b1);
    repeat (2) offer_command(1'b0);
    // full range diagonal with a zero step
    set_line(-2048, 2047, 2047, -2048, 0);
    offer_command(1'b1);
    offer_command(1'b0);
    // steep line, largest step
    set_line(5, -2048, -7, 2047, 15);
    offer_command(1'b1);
    offer_command(1'b0);
    // live registers change the running line
    write_reg(REG_X_END, 2047);
    write_reg(REG_STEP_SIZE, 9);
    offer_command(1'b0);
    // live major delta goes to zero
    write_reg(REG_Y_END, -2048);
    offer_command(1'b0);
    // one point only: last flag, then finished
    set_line(0, 0, 1, 0, 8);
    offer_command(1'b1);
    offer_command(1'b0);

    // random phases of lines
    random_start = commands_offered;
    first_phase = 1'b1;
    while (commands_offered - random_start < RANDOM_COMMANDS) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      area_x = int'($urandom_range(0, 3999)) - 2000;
      area_y = int'($urandom_range(0, 3999)) - 2000;
      foreach (all_regs[i])
        if (first_phase || $urandom_range(0, 4) != 0)
          write_reg(all_regs[i], reg_value(all_regs[i]));
      if (first_phase || $urandom_range(0, 19) == 0) hold_off_req = 1'b1;
      first_phase = 1'b0;
      lines = $urandom_range(1, 4);
      repeat (lines) begin
        if ($urandom_range(0, 9) == 0) offer_command($urandom_range(0, 1));
        offer_command(1'b1);
        span = (cur_x1 > cur_x0) ? cur_x1 - cur_x0 : cur_x0 - cur_x1;
        if (((cur_y1 > cur_y0) ? cur_y1 - cur_y0 : cur_y0 - cur_y1) > span)
          span = (cur_y1 > cur_y0) ? cur_y1 - cur_y0 : cur_y0 - cur_y1;
        stride = (cur_step == 0) ? 1 : cur_step;
        full = (span + stride - 1) / stride;
        if (full <= MAX_WALK && $urandom_range(0, 9) < 7)
          nnext = full - 1 + int'($urandom_range(0, 2));
        else
          nnext = $urandom_range(0, (full < MAX_WALK) ? full : MAX_WALK);
        for (int i = 0; i < nnext; i++) begin
          if ($urandom_range(0, 39) == 0) begin
            lines = lines;
            write_reg(all_regs[$urandom_range(0, 4)], 0);
            write_reg(cfg_index, reg_value(cfg_index));
          end
          offer_command(1'b0);
        end
      end
    end

    // drain
    cmd_valid = 1'b0;
    while (points_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && points_outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/slpg_pkg.sv
rtl/core/stepped_line_point_generator.sv
bench/line_point_checker.sv
bench/tb_stepped_line_point_generator.sv
